// ===== src/xml_tag_balance_checker_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the tag balance checker
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef XML_TAG_BALANCE_CHECKER_MACROS_SVH
`define XML_TAG_BALANCE_CHECKER_MACROS_SVH

// condition holds at every edge
`define XTBC_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds at the edge after the antecedent
`define XTBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds at the same edge as the antecedent
`define XTBC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/xtbc_pkg.sv =====
// ---------------------------------------------------------------------------
// xtbc_pkg
// Sizes, character codes, status codes and scan phases of the tag checker.
// ---------------------------------------------------------------------------
package xtbc_pkg;

   localparam int STACK_DEPTH = 64;   // names that can be open at once
   localparam int NAME_LEN    = 32;   // longest name kept

   localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
   localparam int ROW_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int IDX_W       = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
   localparam int LEN_W       = $clog2(NAME_LEN + 2);   // counts up to NAME_LEN + 1
   localparam int STORE_DEPTH = STACK_DEPTH * NAME_LEN;
   localparam int ST_ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CHAR_W      = 7;
   localparam int LINE_W      = 16;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   typedef enum logic [2:0] {
      ST_FINE       = 3'd0,
      ST_VALID      = 3'd1,
      ST_MISMATCH   = 3'd2,
      ST_BARE_AMP   = 3'd3,
      ST_UNCLOSED   = 3'd4,
      ST_TOO_LONG   = 3'd5,
      ST_STACK_FULL = 3'd6
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_LT    = 5'b00010,
      PH_SLASH = 5'b00100,
      PH_NAME  = 5'b01000,
      PH_REST  = 5'b10000
   } phase_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A);
   endfunction

endpackage

// ===== src/xtbc_req_if.sv =====
// ---------------------------------------------------------------------------
// xtbc_req_if
// Request channel: one document byte or end-of-document marker per transfer.
// ---------------------------------------------------------------------------
interface xtbc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

// ===== src/xtbc_rsp_if.sv =====
// ---------------------------------------------------------------------------
// xtbc_rsp_if
// Response channel: status and line number for each request transfer.
// ---------------------------------------------------------------------------
interface xtbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        finished;
   logic [15:0] line_number;

   modport source (output valid, status, finished, line_number, input ready);
   modport sink   (input valid, status, finished, line_number, output ready);
endinterface

// ===== src/xml_tag_balance_checker.sv =====
// ---------------------------------------------------------------------------
// xml_tag_balance_checker
// Byte-serial checker of tag nesting and ampersand use in a text document.
// ---------------------------------------------------------------------------
// Takes one document byte per transfer (kind 0) and gives one response per
// request transfer: the status so far and the current line number, or the
// line of the first error once one is latched. A transfer with kind 1 marks
// the end of the document: its response carries the final verdict with
// finished set, and the checker then starts afresh for the next document.
// Rate: one byte per clock cycle while the response register can take a
// response, which appears in the cycle after its request transfer. The
// request side keeps taking bytes while a response waits, as long as the
// response register is free or being drained in that cycle. Open names
// live in a name RAM (one row of NAME_LEN characters per stack level) and
// their lengths in a length RAM; both are read every cycle at the address
// that the next byte will need, so a closing name is compared one character
// per byte. No clearing pass: a row is used only after it has been written.
// ---------------------------------------------------------------------------
`include "xml_tag_balance_checker_macros.svh"

module xml_tag_balance_checker (
   input  logic      clock,
   input  logic      reset,
   xtbc_req_if.sink   req_port,
   xtbc_rsp_if.source rsp_port
);

   // ------------------------------------------------------------------
   // Parser state
   // ------------------------------------------------------------------
   logic [xtbc_pkg::TOP_W-1:0]  stack_top_ff,  stack_top_in;
   xtbc_pkg::phase_type         phase_ff,      phase_in;
   logic [xtbc_pkg::LEN_W-1:0]  pending_ff,    pending_in;
   logic                        is_close_ff,   is_close_in;
   logic                        mismatch_ff,   mismatch_in;
   logic [2:0]                  amp_prog_ff,   amp_prog_in;
   logic                        has_amp_ff,    has_amp_in;
   logic                        has_entity_ff, has_entity_in;
   xtbc_pkg::status_type        error_ff,      error_in;
   logic [xtbc_pkg::LINE_W-1:0] line_ff,       line_in;

   // length forwarding: a push followed at once by a read of the same row
   logic                        fwd_valid_ff,  fwd_valid_in;
   logic [xtbc_pkg::LEN_W-1:0]  fwd_len_ff,    fwd_len_in;

   // response register
   logic                        rsp_valid_ff,  rsp_valid_in;
   xtbc_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic                        rsp_fin_ff,    rsp_fin_in;
   logic [xtbc_pkg::LINE_W-1:0] rsp_line_ff,   rsp_line_in;

   // ------------------------------------------------------------------
   // Memory ports
   // ------------------------------------------------------------------
   logic                            st_we;
   logic [xtbc_pkg::ST_ADDR_W-1:0]  st_waddr, st_raddr;
   logic [xtbc_pkg::CHAR_W-1:0]     st_wdata, st_rdata;
   logic                            len_we;
   logic [xtbc_pkg::ROW_W-1:0]      len_waddr, len_raddr;
   logic [xtbc_pkg::LEN_W-1:0]      len_wdata, len_rdata;

   logic [xtbc_pkg::LEN_W-1:0]      top_len;
   logic [xtbc_pkg::ROW_W-1:0]      rd_row;
   logic [xtbc_pkg::IDX_W-1:0]      rd_idx;
   logic                            accept;

   assign accept         = req_port.valid && req_port.ready;
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;

   // length of the top name, taken from the push just made if there was one
   assign top_len = fwd_valid_ff ? fwd_len_ff : len_rdata;

   // ------------------------------------------------------------------
   // Next state for one transfer
   // ------------------------------------------------------------------
   always_comb begin
      logic [7:0]                 c;
      logic                       do_add;
      logic                       do_done;
      logic [xtbc_pkg::LEN_W-1:0] cur_i;
      logic                       amp_fail;

      c        = req_port.data_byte;
      do_add   = 1'b0;
      do_done  = 1'b0;
      cur_i    = pending_ff;
      amp_fail = has_amp_ff && !has_entity_ff;

      stack_top_in  = stack_top_ff;
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      is_close_in   = is_close_ff;
      mismatch_in   = mismatch_ff;
      amp_prog_in   = amp_prog_ff;
      has_amp_in    = has_amp_ff;
      has_entity_in = has_entity_ff;
      error_in      = error_ff;
      line_in       = line_ff;

      st_we     = 1'b0;
      st_waddr  = xtbc_pkg::ST_ADDR_W'(stack_top_ff[xtbc_pkg::ROW_W-1:0])
                  * xtbc_pkg::ST_ADDR_W'(xtbc_pkg::NAME_LEN)
                  + xtbc_pkg::ST_ADDR_W'(pending_ff[xtbc_pkg::IDX_W-1:0]);
      st_wdata  = c[xtbc_pkg::CHAR_W-1:0];
      len_we    = 1'b0;
      len_waddr = stack_top_ff[xtbc_pkg::ROW_W-1:0];
      len_wdata = pending_ff;

      rsp_valid_in  = rsp_port.ready ? 1'b0 : rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_line_in   = rsp_line_ff;

      if (accept && req_port.kind) begin
         // end of document: final verdict, then back to reset state
         if (error_ff == xtbc_pkg::ST_FINE) begin
            if (amp_fail) begin
               error_in = xtbc_pkg::ST_BARE_AMP;
            end else if (stack_top_ff != '0) begin
               error_in = xtbc_pkg::ST_UNCLOSED;
            end else begin
               error_in = xtbc_pkg::ST_VALID;
            end
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = error_in;
         rsp_fin_in    = 1'b1;
         rsp_line_in   = line_ff;

         stack_top_in  = '0;
         phase_in      = xtbc_pkg::PH_IDLE;
         pending_in    = '0;
         is_close_in   = 1'b0;
         mismatch_in   = 1'b0;
         amp_prog_in   = '0;
         has_amp_in    = 1'b0;
         has_entity_in = 1'b0;
         error_in      = xtbc_pkg::ST_FINE;
         line_in       = xtbc_pkg::LINE_W'(1);
      end else if (accept) begin
         if (error_ff == xtbc_pkg::ST_FINE) begin
            if (c == xtbc_pkg::CH_NL) begin
               phase_in = xtbc_pkg::PH_IDLE;
               if (amp_fail) begin
                  error_in = xtbc_pkg::ST_BARE_AMP;
               end else begin
                  has_amp_in    = 1'b0;
                  has_entity_in = 1'b0;
                  amp_prog_in   = '0;
                  if (line_ff != '1) begin
                     line_in = line_ff + 1'b1;
                  end
               end
            end else begin
               // "&amp;" tracker
               if (c == xtbc_pkg::CH_AMP) begin
                  has_amp_in  = 1'b1;
                  amp_prog_in = 3'd1;
               end else if ((amp_prog_ff == 3'd1 && c == xtbc_pkg::CH_A) ||
                            (amp_prog_ff == 3'd2 && c == xtbc_pkg::CH_M) ||
                            (amp_prog_ff == 3'd3 && c == xtbc_pkg::CH_P)) begin
                  amp_prog_in = amp_prog_ff + 3'd1;
               end else if (amp_prog_ff == 3'd4 && c == xtbc_pkg::CH_SEMI) begin
                  has_entity_in = 1'b1;
                  amp_prog_in   = '0;
               end else begin
                  amp_prog_in = '0;
               end

               // tag scanner
               case (phase_ff)
                  xtbc_pkg::PH_LT: begin
                     if (c == xtbc_pkg::CH_SLASH) begin
                        phase_in = xtbc_pkg::PH_SLASH;
                     end else if (xtbc_pkg::is_alnum(c)) begin
                        phase_in    = xtbc_pkg::PH_NAME;
                        is_close_in = 1'b0;
                        mismatch_in = 1'b0;
                        cur_i       = '0;
                        do_add      = 1'b1;
                     end else begin
                        phase_in = (c == xtbc_pkg::CH_LT) ? xtbc_pkg::PH_LT
                                                          : xtbc_pkg::PH_IDLE;
                     end
                  end
                  xtbc_pkg::PH_SLASH: begin
                     if (xtbc_pkg::is_alnum(c)) begin
                        phase_in    = xtbc_pkg::PH_NAME;
                        is_close_in = 1'b1;
                        mismatch_in = (stack_top_ff == '0);
                        cur_i       = '0;
                        do_add      = 1'b1;
                     end else begin
                        phase_in = (c == xtbc_pkg::CH_LT) ? xtbc_pkg::PH_LT
                                                          : xtbc_pkg::PH_IDLE;
                     end
                  end
                  xtbc_pkg::PH_NAME: begin
                     if (xtbc_pkg::is_alnum(c)) begin
                        do_add = 1'b1;
                     end else if (c == xtbc_pkg::CH_GT) begin
                        do_done = 1'b1;
                     end else begin
                        phase_in = xtbc_pkg::PH_REST;
                     end
                  end
                  xtbc_pkg::PH_REST: begin
                     if (c == xtbc_pkg::CH_GT) begin
                        do_done = 1'b1;
                     end
                  end
                  default: begin
                     phase_in = (c == xtbc_pkg::CH_LT) ? xtbc_pkg::PH_LT
                                                       : xtbc_pkg::PH_IDLE;
                  end
               endcase

               // one name character: compare against the top name, or store it
               if (do_add) begin
                  if (is_close_in) begin
                     if (stack_top_ff == '0 ||
                         cur_i >= xtbc_pkg::LEN_W'(xtbc_pkg::NAME_LEN) ||
                         cur_i >= top_len ||
                         {1'b0, st_rdata} != c) begin
                        mismatch_in = 1'b1;
                     end
                  end else if (cur_i < xtbc_pkg::LEN_W'(xtbc_pkg::NAME_LEN) &&
                               stack_top_ff < xtbc_pkg::TOP_W'(xtbc_pkg::STACK_DEPTH)) begin
                     st_we    = 1'b1;
                     st_waddr = xtbc_pkg::ST_ADDR_W'(stack_top_ff[xtbc_pkg::ROW_W-1:0])
                                * xtbc_pkg::ST_ADDR_W'(xtbc_pkg::NAME_LEN)
                                + xtbc_pkg::ST_ADDR_W'(cur_i[xtbc_pkg::IDX_W-1:0]);
                  end
                  pending_in = (cur_i <= xtbc_pkg::LEN_W'(xtbc_pkg::NAME_LEN))
                               ? cur_i + 1'b1 : cur_i;
               end

               // closing '>' of a tag: pop on a matching close, push on an open, else latch an error
               if (do_done) begin
                  phase_in = xtbc_pkg::PH_IDLE;
                  if (is_close_ff) begin
                     if (mismatch_ff || stack_top_ff == '0 || pending_ff != top_len) begin
                        error_in = xtbc_pkg::ST_MISMATCH;
                     end else begin
                        stack_top_in = stack_top_ff - 1'b1;
                     end
                  end else if (pending_ff > xtbc_pkg::LEN_W'(xtbc_pkg::NAME_LEN)) begin
                     error_in = xtbc_pkg::ST_TOO_LONG;
                  end else if (stack_top_ff >= xtbc_pkg::TOP_W'(xtbc_pkg::STACK_DEPTH)) begin
                     error_in = xtbc_pkg::ST_STACK_FULL;
                  end else begin
                     len_we       = 1'b1;
                     stack_top_in = stack_top_ff + 1'b1;
                  end
               end
            end
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = error_in;
         rsp_fin_in    = 1'b0;
         rsp_line_in   = line_in;
      end

      fwd_valid_in = len_we;
      fwd_len_in   = len_wdata;
   end

   // ------------------------------------------------------------------
   // Read addresses follow the next state: the row under the top of the
   // stack and the character that the next name byte will be compared with.
   // The name RAM is never written and read at the same row in one cycle
   // (writes go to the row above the top); the length RAM is, after a push,
   // and that case is forwarded.
   // ------------------------------------------------------------------
   always_comb begin
      logic [xtbc_pkg::TOP_W-1:0] below_top;
      below_top = stack_top_in - 1'b1;
      rd_row    = below_top[xtbc_pkg::ROW_W-1:0];
      if (phase_in == xtbc_pkg::PH_NAME &&
          pending_in < xtbc_pkg::LEN_W'(xtbc_pkg::NAME_LEN)) begin
         rd_idx = pending_in[xtbc_pkg::IDX_W-1:0];
      end else begin
         rd_idx = '0;
      end
   end

   assign st_raddr  = xtbc_pkg::ST_ADDR_W'(rd_row) * xtbc_pkg::ST_ADDR_W'(xtbc_pkg::NAME_LEN)
                      + xtbc_pkg::ST_ADDR_W'(rd_idx);
   assign len_raddr = rd_row;

   xtbc_ram #(
      .WIDTH (xtbc_pkg::CHAR_W),
      .DEPTH (xtbc_pkg::STORE_DEPTH)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   xtbc_ram #(
      .WIDTH (xtbc_pkg::LEN_W),
      .DEPTH (xtbc_pkg::STACK_DEPTH)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_addr (len_raddr),
      .rd_data (len_rdata)
   );

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_top_ff  <= '0;
         phase_ff      <= xtbc_pkg::PH_IDLE;
         pending_ff    <= '0;
         is_close_ff   <= 1'b0;
         mismatch_ff   <= 1'b0;
         amp_prog_ff   <= '0;
         has_amp_ff    <= 1'b0;
         has_entity_ff <= 1'b0;
         error_ff      <= xtbc_pkg::ST_FINE;
         line_ff       <= xtbc_pkg::LINE_W'(1);
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         stack_top_ff  <= stack_top_in;
         phase_ff      <= phase_in;
         pending_ff    <= pending_in;
         is_close_ff   <= is_close_in;
         mismatch_ff   <= mismatch_in;
         amp_prog_ff   <= amp_prog_in;
         has_amp_ff    <= has_amp_in;
         has_entity_ff <= has_entity_in;
         error_ff      <= error_in;
         line_ff       <= line_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_len_ff    <= fwd_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_line_ff   <= rsp_line_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.finished    = rsp_fin_ff;
   assign rsp_port.line_number = rsp_line_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `XTBC_ASSERT_HOLDS(a_stack_bound, stack_top_ff <= xtbc_pkg::TOP_W'(xtbc_pkg::STACK_DEPTH), "stack top beyond depth")
   `XTBC_ASSERT_NEXT(a_error_latched, accept && !req_port.kind && error_ff != xtbc_pkg::ST_FINE, error_ff == $past(error_ff), "latched error changed on a document byte")
   `XTBC_ASSERT_NEXT(a_end_clears, accept && req_port.kind, stack_top_ff == '0 && error_ff == xtbc_pkg::ST_FINE && line_ff == xtbc_pkg::LINE_W'(1), "state not cleared after end of document")
   `XTBC_ASSERT_NEXT(a_line_idle, !accept, $stable(line_ff) && $stable(stack_top_ff), "state moved without a transfer")
   `XTBC_ASSERT_SAME(a_final_verdict, rsp_valid_ff && rsp_fin_ff, rsp_status_ff != xtbc_pkg::ST_FINE, "final response without a verdict")

endmodule

// ===== src/xtbc_ram.sv =====
// ---------------------------------------------------------------------------
// xtbc_ram
// Single write port, single read port RAM; read data registered, old data
// returned on a same-address write.
// ---------------------------------------------------------------------------
module xtbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Tag balance checker testbench
// A table of short documents (reset state, extremes, every error code and the
// corner cases of tag scanning), then random documents made mostly of well
// formed tags, text and entities with some noise. Every response is checked
// against a quoted table verdict or an in-bench nesting/ampersand predictor.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import xtbc_pkg::*;

   localparam int CYCLE_LIMIT   = 50_000;    // several times the slowest legal run
   localparam int HOLD_CYCLES   = 60;        // long receiver hold-off
   localparam int RANDOM_ITEMS  = 200;

   // one response as the checker should give it
   typedef struct packed {
      status_type  status;
      logic        finished;
      logic [15:0] line;
   } verdict_type;

   // verdict quoted in the table, taking the place of the prediction
   typedef struct packed {
      bit          known;
      verdict_type v;
   } quoted_type;

   // one table row: head, body repeated reps times, tail, then end of document
   typedef struct {
      string       head;
      string       body;
      int          reps;
      string       tail;
      bit          known;
      status_type  status;
      logic [15:0] line;
   } doc_row_type;

   logic clock;
   logic reset;

   xtbc_req_if req_bus ();
   xtbc_rsp_if rsp_bus ();

   xml_tag_balance_checker u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   verdict_type pending_verdicts [$];   // expected responses, oldest first
   quoted_type  quoted_verdicts  [$];   // one entry per request on offer
   int       mismatches  = 0;
   int       items_sent  = 0;
   int       cycle_count = 0;
   bit       idle_on     = 1'b1;     // random gaps on both sides
   bit       hold_request = 1'b0;    // asks the receiver for one long hold-off

   // -------------------------------------------------------------------------
   // Predictor state: stack of open names and the scanner of the current line
   // -------------------------------------------------------------------------
   logic [6:0]  open_names [STACK_DEPTH][NAME_LEN];
   int          open_lens  [STACK_DEPTH];
   int          depth;
   phase_type   scan_at;
   int          name_len;      // saturates at NAME_LEN + 1
   bit          closing_tag;
   bit          close_bad;     // close name already known not to match the top
   int          amp_state;     // how much of "&amp;" has been seen
   bit          saw_amp;
   bit          saw_entity;
   status_type  latched;
   logic [15:0] cur_line;

   function automatic void clear_nesting();
      foreach (open_lens[i]) open_lens[i] = 0;
      depth       = 0;
      scan_at     = PH_IDLE;
      name_len    = 0;
      closing_tag = 1'b0;
      close_bad   = 1'b0;
      amp_state   = 0;
      saw_amp     = 1'b0;
      saw_entity  = 1'b0;
      latched     = ST_FINE;
      cur_line    = 16'd1;
   endfunction

   function automatic void begin_name(input bit is_close);
      closing_tag = is_close;
      name_len    = 0;
      close_bad   = is_close && depth == 0;
      scan_at     = PH_NAME;
   endfunction

   // a close name is compared against the top row as it arrives;
   // an open name is written into the row it will occupy
   function automatic void name_char(input logic [7:0] b);
      if (closing_tag) begin
         if (depth > 0) begin
            if (name_len >= NAME_LEN || name_len >= open_lens[depth-1])
               close_bad = 1'b1;
            else if ({1'b0, open_names[depth-1][name_len]} != b)
               close_bad = 1'b1;
         end else begin
            close_bad = 1'b1;
         end
      end else if (name_len < NAME_LEN && depth < STACK_DEPTH) begin
         open_names[depth][name_len] = b[6:0];
      end
      if (name_len <= NAME_LEN) name_len++;
   endfunction

   function automatic void finish_tag();
      scan_at = PH_IDLE;
      if (closing_tag) begin
         if (close_bad || depth == 0 || name_len != open_lens[depth-1])
            latched = ST_MISMATCH;
         else
            depth--;
      end else if (name_len > NAME_LEN) begin
         latched = ST_TOO_LONG;
      end else if (depth >= STACK_DEPTH) begin
         latched = ST_STACK_FULL;
      end else begin
         open_lens[depth] = name_len;
         depth++;
      end
   endfunction

   // advances the predictor by one request transfer, returns the response due
   function automatic verdict_type nesting_verdict(input logic kind, input logic [7:0] b);
      verdict_type v;
      bit          alnum;
      alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
              (b >= 8'h61 && b <= 8'h7A);
      if (kind == 1'b0) begin
         if (latched == ST_FINE) begin
            if (b == CH_NL) begin
               // line ends: a pending tag is dropped, then the ampersand rule
               scan_at = PH_IDLE;
               if (saw_amp && !saw_entity) begin
                  latched = ST_BARE_AMP;
               end else begin
                  saw_amp    = 1'b0;
                  saw_entity = 1'b0;
                  amp_state  = 0;
                  if (cur_line != 16'hFFFF) cur_line++;
               end
            end else begin
               if (b == CH_AMP) begin
                  saw_amp   = 1'b1;
                  amp_state = 1;
               end else if ((amp_state == 1 && b == CH_A) || (amp_state == 2 && b == CH_M) ||
                            (amp_state == 3 && b == CH_P)) begin
                  amp_state++;
               end else if (amp_state == 4 && b == CH_SEMI) begin
                  saw_entity = 1'b1;
                  amp_state  = 0;
               end else begin
                  amp_state = 0;
               end
               case (scan_at)
                  PH_LT: begin
                     if (b == CH_SLASH) scan_at = PH_SLASH;
                     else if (alnum) begin
                        begin_name(1'b0);
                        name_char(b);
                     end else scan_at = (b == CH_LT) ? PH_LT : PH_IDLE;
                  end
                  PH_SLASH: begin
                     if (alnum) begin
                        begin_name(1'b1);
                        name_char(b);
                     end else scan_at = (b == CH_LT) ? PH_LT : PH_IDLE;
                  end
                  PH_NAME: begin
                     if (alnum) name_char(b);
                     else if (b == CH_GT) finish_tag();
                     else scan_at = PH_REST;
                  end
                  PH_REST: begin
                     if (b == CH_GT) finish_tag();
                  end
                  default: begin
                     scan_at = (b == CH_LT) ? PH_LT : PH_IDLE;
                  end
               endcase
            end
         end
         v = '{latched, 1'b0, cur_line};
      end else begin
         // end of document: ampersand rule first, then open names
         if (latched == ST_FINE) begin
            if (saw_amp && !saw_entity) latched = ST_BARE_AMP;
            else if (depth != 0)        latched = ST_UNCLOSED;
            else                        latched = ST_VALID;
         end
         v = '{latched, 1'b1, cur_line};
         clear_nesting();
      end
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // Clock, cycle limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Checking: responses against the oldest expectation, then new predictions.
   // Sampled at the edge, so every value seen is the one settled before it.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      verdict_type want;
      quoted_type  quote;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch("response with none expected", 16'(rsp_bus.status), 16'hx);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 16'(rsp_bus.status), 16'(want.status));
               if (rsp_bus.finished !== want.finished)
                  report_mismatch("finished", 16'(rsp_bus.finished), 16'(want.finished));
               if (rsp_bus.line_number !== want.line)
                  report_mismatch("line_number", rsp_bus.line_number, want.line);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            // predictor always advances; a quoted verdict overrides its answer
            want = nesting_verdict(req_bus.kind, req_bus.data_byte);
            if (quoted_verdicts.size() != 0) begin
               quote = quoted_verdicts.pop_front();
               if (quote.known) want = quote.v;
            end
            pending_verdicts.insert(pending_verdicts.size(), want);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls, and one long hold-off on request so that the
   // response register fills and the request side stalls behind it
   // -------------------------------------------------------------------------
   initial begin : receiver
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = idle_on ? $urandom_range(0, 3) : 0;
         repeat (stall) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   // offers one request and returns at the edge of its transfer; valid stays
   // high into the next request when no gap is drawn
   task automatic offer(input logic kind, input logic [7:0] b, input bit known,
                        input verdict_type v);
      int         gap;
      quoted_type quote;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      quote.known = known;
      quote.v     = v;
      quoted_verdicts.insert(quoted_verdicts.size(), quote);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) offer(1'b0, s[i], 1'b0, '0);
   endtask

   task automatic wait_for_verdicts();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // removes and returns the most recently opened name
   function automatic string take_newest(ref string names [$]);
      string s;
      s = names[names.size() - 1];
      names.delete(names.size() - 1);
      return s;
   endfunction

   function automatic string random_name();
      string s;
      int    n, c, pick;
      pick = $urandom_range(0, 99);
      if (pick < 90)      n = $urandom_range(1, 4);
      else if (pick < 98) n = $urandom_range(NAME_LEN - 4, NAME_LEN);
      else                n = $urandom_range(NAME_LEN + 1, NAME_LEN + 2);
      s = "";
      repeat (n) begin
         c = $urandom_range(0, 61);
         if (c < 10)      c = 8'h30 + c;
         else if (c < 36) c = 8'h41 + c - 10;
         else             c = 8'h61 + c - 36;
         s = $sformatf("%s%c", s, c[7:0]);
      end
      return s;
   endfunction

   // one document of mostly sound nesting with random names, text and
   // entities; a few dropped tags, wrong closes, bare ampersands and noise
   task automatic random_document();
      string nm;
      string open_q [$];
      int    budget, start, r, c;
      start  = items_sent;
      budget = $urandom_range(8, 60);
      while (items_sent - start < budget) begin
         r = $urandom_range(0, 99);
         if (r < 30 || (r < 55 && open_q.size() == 0)) begin
            nm = random_name();
            if ($urandom_range(0, 19) == 0) begin
               put_text({"<", nm, "\n"});            // tag cut by the line end
            end else begin
               put_text({"<", nm});
               if ($urandom_range(0, 2) == 0) put_text(" k=\"v<\"");
               put_text(">");
               open_q.insert(open_q.size(), nm);
            end
         end else if (r < 55) begin
            nm = take_newest(open_q);
            if ($urandom_range(0, 19) == 0) nm = {nm, "Q"};   // wrong close
            put_text({"</", nm, ">"});
         end else if (r < 70) begin
            repeat ($urandom_range(1, 6)) begin
               c = $urandom_range(32, 126);
               if (c == 8'h3C || c == 8'h26) c = 8'h20;
               offer(1'b0, c[7:0], 1'b0, '0);
            end
         end else if (r < 78) begin
            put_text($urandom_range(0, 1) ? "&amp;" : "&&amp;");
         end else if (r < 88) begin
            put_text($urandom_range(0, 3) == 0 ? "\015\n" : "\n");
         end else if (r < 91) begin
            put_text("&");
         end else begin
            offer(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
         end
      end
      if ($urandom_range(0, 4) != 0)
         while (open_q.size() != 0) put_text({"</", take_newest(open_q), ">"});
      if ($urandom_range(0, 1) == 1) put_text("\n");
      offer(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   // -------------------------------------------------------------------------
   // Directed documents. Verdicts are quoted only where they are plain.
   // -------------------------------------------------------------------------
   doc_row_type doc_table [] = '{
      // end of document straight after reset
      '{"", "", 0, "", 1'b1, ST_VALID, 16'd1},
      '{"<a1>x</a1>\n", "", 0, "", 1'b1, ST_VALID, 16'd2},
      // close with nothing open
      '{"</b>", "", 0, "", 1'b1, ST_MISMATCH, 16'd1},
      '{"<ab></ac>", "", 0, "", 1'b1, ST_MISMATCH, 16'd1},
      '{"<abc></ab>", "", 0, "", 1'b0, ST_FINE, 16'd0},
      '{"a&b\n", "", 0, "", 1'b1, ST_BARE_AMP, 16'd1},
      '{"&amp;&\n", "", 0, "", 1'b1, ST_VALID, 16'd2},
      '{"&am;\n", "", 0, "", 1'b0, ST_FINE, 16'd0},
      // left open, count one past the last line
      '{"<z>\n", "", 0, "", 1'b1, ST_UNCLOSED, 16'd2},
      // last line unterminated: ampersand rule wins over open names
      '{"<q>&", "", 0, "", 1'b1, ST_BARE_AMP, 16'd1},
      // tag cut by the line end is dropped
      '{"<a\n>", "", 0, "", 1'b1, ST_VALID, 16'd2},
      // longest name kept, then one too long, open and close
      '{"<", "y", NAME_LEN, ">", 1'b1, ST_UNCLOSED, 16'd1},
      '{"<", "x", NAME_LEN + 1, ">", 1'b1, ST_TOO_LONG, 16'd1},
      '{"<a></", "x", NAME_LEN + 1, ">", 1'b1, ST_MISMATCH, 16'd1},
      // stack exactly full, then one more
      '{"", "<t>", STACK_DEPTH, "", 1'b1, ST_UNCLOSED, 16'd1},
      '{"", "<t>", STACK_DEPTH + 1, "", 1'b1, ST_STACK_FULL, 16'd1},
      // bytes after an error are ignored and the line freezes
      '{"</a>\nmore&\n", "", 0, "", 1'b1, ST_MISMATCH, 16'd1},
      '{"<<a>< /a></a>\n", "", 0, "", 1'b1, ST_VALID, 16'd2},
      // '<' after the name, CR and a top-bit byte are ordinary
      '{"<a <b>\015\377</a>", "", 0, "", 1'b1, ST_VALID, 16'd1},
      '{"<0aZ9zA></0aZ9zA><@x>[`{:/>", "", 0, "", 1'b0, ST_FINE, 16'd0}
   };

   initial begin : stimulus
      verdict_type quoted;
      int          docs;
      int          first_random;
      clear_nesting();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= 1'b0;
      req_bus.data_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (doc_table[i]) begin
         put_text(doc_table[i].head);
         repeat (doc_table[i].reps) put_text(doc_table[i].body);
         put_text(doc_table[i].tail);
         quoted = '{doc_table[i].status, 1'b1, doc_table[i].line};
         offer(1'b1, (i % 2 == 1) ? 8'hFF : 8'h00, doc_table[i].known, quoted);
      end

      first_random = items_sent;
      docs = 0;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (docs == 0) begin
            // long hold-off while the sender keeps offering
            idle_on      = 1'b0;
            hold_request = 1'b1;
         end
         random_document();
         if (docs == 0) wait_for_verdicts();
         docs++;
      end

      idle_on = 1'b1;
      wait_for_verdicts();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
